@@ rtl/core/mrf_pkg.sv @@
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants of the request framer
// Function codes, CRC constants, the frame load record passed from the
// builder to the serializer, and the byte-wise CRC-16 update.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int FRAME_BYTES = 9;

  localparam logic [7:0]  FN_READ       = 8'h03;
  localparam logic [7:0]  FN_WRITE_ONE  = 8'h06;
  localparam logic [7:0]  FN_WRITE_MANY = 8'h10;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  BYTE_MASK     = 8'hFF;

  // register indexes of the configuration port
  localparam logic CFG_STATION = 1'b0;
  localparam logic CFG_BASE    = 1'b1;

  // frame bytes for one item, byte 0 goes out first
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [3:0]                  n_data;
    logic                        crc_tail;
  } frame_load_t;

  // framing progress between items
  typedef struct packed {
    logic       in_write_frame;
    logic [6:0] words_left;
  } frame_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/core/mrf_frame_builder.sv @@
// ----------------------------------------------------------------------------
// mrf_frame_builder: request item decode
// Turns one request item and the framing progress into the frame bytes it
// produces and the progress that follows it.
// ----------------------------------------------------------------------------
module mrf_frame_builder #(
  parameter int MAX_WRITE_WORDS = 123
) (
  input  logic                 op,
  input  logic [15:0]          reg_addr,
  input  logic [6:0]           reg_count,
  input  logic [15:0]          data_word,
  input  logic [7:0]           station,
  input  logic [15:0]          base,
  input  mrf_pkg::frame_state_t fs,
  output mrf_pkg::frame_load_t  load,
  output logic                 emit,
  output mrf_pkg::frame_state_t fs_nxt
);

  localparam logic [6:0] MAX_W = 7'(MAX_WRITE_WORDS);

  logic [15:0] full_addr;
  logic [6:0]  cnt_sat;
  logic [6:0]  wl_dec;

  assign full_addr = reg_addr + base;
  assign cnt_sat   = (reg_count > MAX_W) ? MAX_W : reg_count;
  assign wl_dec    = (fs.words_left != 7'd0) ? fs.words_left - 7'd1 : fs.words_left;

  always_comb begin
    load     = '0;
    emit     = 1'b1;
    fs_nxt   = fs;
    if (fs.in_write_frame) begin
      // next data word of a multiple-register write
      load.bytes[0] = data_word[15:8];
      load.bytes[1] = data_word[7:0];
      load.n_data   = 4'd2;
      fs_nxt.words_left = wl_dec;
      if (wl_dec == 7'd0) begin
        load.crc_tail = 1'b1;
        fs_nxt        = '0;
      end
    end else if (!op) begin
      load.bytes[0] = station;
      load.bytes[1] = mrf_pkg::FN_READ;
      load.bytes[2] = full_addr[15:8];
      load.bytes[3] = full_addr[7:0];
      load.bytes[4] = 8'h00;
      load.bytes[5] = {1'b0, reg_count};
      load.n_data   = 4'd6;
      load.crc_tail = 1'b1;
    end else if (reg_count == 7'd0) begin
      // write of nothing: item dropped
      emit = 1'b0;
    end else if (cnt_sat == 7'd1) begin
      load.bytes[0] = station;
      load.bytes[1] = mrf_pkg::FN_WRITE_ONE;
      load.bytes[2] = full_addr[15:8];
      load.bytes[3] = full_addr[7:0];
      load.bytes[4] = data_word[15:8];
      load.bytes[5] = data_word[7:0];
      load.n_data   = 4'd6;
      load.crc_tail = 1'b1;
    end else begin
      load.bytes[0] = station;
      load.bytes[1] = mrf_pkg::FN_WRITE_MANY;
      load.bytes[2] = full_addr[15:8];
      load.bytes[3] = full_addr[7:0];
      load.bytes[4] = 8'h00;
      load.bytes[5] = {1'b0, cnt_sat};
      load.bytes[6] = {cnt_sat, 1'b0} & mrf_pkg::BYTE_MASK;
      load.bytes[7] = data_word[15:8];
      load.bytes[8] = data_word[7:0];
      load.n_data   = 4'd9;
      fs_nxt.in_write_frame = 1'b1;
      fs_nxt.words_left     = cnt_sat - 7'd1;
    end
  end

endmodule

@@ rtl/core/mrf_byte_serializer.sv @@
// ----------------------------------------------------------------------------
// mrf_byte_serializer: frame byte shifter with CRC
// Shifts the loaded frame bytes into the output register one per cycle unless
// stalled, folds each into the CRC and appends the CRC low byte first when asked.
// ----------------------------------------------------------------------------
module mrf_byte_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  mrf_pkg::frame_load_t load,
  output logic                free,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_tx_byte,
  output logic                out_frame_end
);

  logic [mrf_pkg::FRAME_BYTES-1:0][7:0] sh_r;
  logic [3:0]  data_left_r;
  logic [1:0]  crc_left_r;
  logic [15:0] crc_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;

  logic busy;
  logic advance;
  logic step;
  logic last;

  assign busy    = (data_left_r != 4'd0) || (crc_left_r != 2'd0);
  assign advance = !out_valid_r || !out_stall;
  assign step    = busy && advance;
  assign last    = ((data_left_r == 4'd1) && (crc_left_r == 2'd0)) ||
                   ((data_left_r == 4'd0) && (crc_left_r == 2'd1));
  assign free    = !busy || (step && last);

  // output register and crc
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= mrf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
        if (data_left_r != 4'd0) begin
          out_byte_r <= sh_r[0];
          out_end_r  <= 1'b0;
          crc_r      <= mrf_pkg::crc_byte(crc_r, sh_r[0]);
        end else if (crc_left_r == 2'd2) begin
          out_byte_r <= crc_r[7:0];
          out_end_r  <= 1'b0;
        end else begin
          out_byte_r <= crc_r[15:8];
          out_end_r  <= 1'b1;
          crc_r      <= mrf_pkg::CRC_INIT;
        end
      end else if (advance) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // shift register and byte counters; a load replaces the drained last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_left_r <= 4'd0;
      crc_left_r  <= 2'd0;
    end else if (ld) begin
      sh_r        <= load.bytes;
      data_left_r <= load.n_data;
      crc_left_r  <= load.crc_tail ? 2'd2 : 2'd0;
    end else if (step) begin
      if (data_left_r != 4'd0) begin
        sh_r        <= {8'h00, sh_r[mrf_pkg::FRAME_BYTES-1:1]};
        data_left_r <= data_left_r - 4'd1;
      end else if (crc_left_r == 2'd2) begin
        crc_left_r <= 2'd1;
      end else begin
        crc_left_r <= 2'd0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule

@@ rtl/core/modbus_rtu_request_framer.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer: Modbus RTU master request frame generator
// Turns read and write request beats into the byte stream of RTU request
// frames (functions 0x03, 0x06, 0x10) with CRC-16/MODBUS, low byte first.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  request  | in_valid in_stall in_op in_reg_addr           | in
//           | in_reg_count in_data_word                     |
//  frame    | out_valid out_stall out_tx_byte out_frame_end | out
//  config   | cfg_wr_en cfg_index cfg_wdata                 | in
//
//  a request beat yields up to 9 frame bytes, one byte per cycle unless
//  out_stall holds the output; the output byte rate sets the pace;
//  a zero-count write yields nothing and still leaves the input register
//  an input register holds the next beat while the current one shifts out
//  reset: synchronous, active low; station 3, base 0, no frame open
//  out_stall holds the output register and, once the input register is
//  full and the serializer still has bytes to send, raises in_stall in the same cycle
//
module modbus_rtu_request_framer #(
  parameter int MAX_WRITE_WORDS = 123
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_reg_addr,
  input  logic [6:0]  in_reg_count,
  input  logic [15:0] in_data_word,
  // frame byte channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [7:0]  station_r;
  logic [15:0] base_r;

  // input register
  logic        a_valid_r;
  logic        a_op_r;
  logic [15:0] a_addr_r;
  logic [6:0]  a_count_r;
  logic [15:0] a_data_r;

  // framing progress across beats
  mrf_pkg::frame_state_t fs_r;
  mrf_pkg::frame_state_t fs_nxt;

  mrf_pkg::frame_load_t load;
  logic emit;
  logic ser_free;
  logic a_take;
  logic in_acc;

  assign a_take   = a_valid_r && ser_free;
  assign in_stall = a_valid_r && !ser_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 8'd3;
      base_r    <= 16'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mrf_pkg::CFG_STATION: station_r <= cfg_wdata[7:0];
        mrf_pkg::CFG_BASE:    base_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register: refills in the cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_take) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op_r    <= in_op;
      a_addr_r  <= in_reg_addr;
      a_count_r <= in_reg_count;
      a_data_r  <= in_data_word;
    end
  end

  // progress moves on when the beat is handed to the serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '0;
    end else if (a_take) begin
      fs_r <= fs_nxt;
    end
  end

  mrf_frame_builder #(
    .MAX_WRITE_WORDS(MAX_WRITE_WORDS)
  ) u_builder (
    .op       (a_op_r),
    .reg_addr (a_addr_r),
    .reg_count(a_count_r),
    .data_word(a_data_r),
    .station  (station_r),
    .base     (base_r),
    .fs       (fs_r),
    .load     (load),
    .emit     (emit),
    .fs_nxt   (fs_nxt)
  );

  // zero-count writes are taken but load nothing
  mrf_byte_serializer u_serializer (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (a_take && emit),
    .load         (load),
    .free         (ser_free),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_tx_byte  (out_tx_byte),
    .out_frame_end(out_frame_end)
  );

endmodule

@@ rtl/core/mrf_checker.sv @@
// ----------------------------------------------------------------------------
// mrf_checker: port-level checks of the request framer
// Watches the top-level ports for reset behavior, output hold under stall
// and a minimum frame length.
// ----------------------------------------------------------------------------
module mrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_tx_byte,
  input logic       out_frame_end
);

  // accepted bytes since the last frame end, saturating at 8
  logic [3:0] bytes_r;
  logic       out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= 4'd0;
    end else if (out_beat) begin
      if (out_frame_end) begin
        bytes_r <= 4'd0;
      end else if (bytes_r != 4'd8) begin
        bytes_r <= bytes_r + 4'd1;
      end
    end
  end

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_frame_end))
    else $error("stalled frame beat changed");

  a_min_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && out_frame_end |-> bytes_r >= 4'd7)
    else $error("frame shorter than eight bytes");

endmodule

bind modbus_rtu_request_framer mrf_checker u_mrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_tx_byte  (out_tx_byte),
  .out_frame_end(out_frame_end)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: request framer byte-stream check
// Sends read and write request beats with random gaps while the frame side
// stalls at random. Every frame byte, CRC included, is predicted in order and
// compared. Register settings change between frames and while a multi-register
// write waits for its words.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int     MAX_WRITE_WORDS = 123;
  localparam int     MAX_GAP         = 12;
  localparam int     SETTLE_CYCLES   = 24;   // an ignored beat may still be in the input register
  localparam int     N_PHASES        = 8;
  localparam int     PHASE_ITEMS     = 15;
  localparam int     NO_TYPED        = -1;
  localparam longint TIMEOUT_NS      = 64'd12_000_000;

  typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} req_op_t;
  typedef enum logic [1:0] {ROW_REQ, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct {
    req_op_t     op;
    logic [15:0] addr;
    logic [6:0]  cnt;
    logic [15:0] data;
  } req_t;

  typedef struct {
    logic [7:0] tx;
    logic       last;
  } frame_byte_t;

  // one step of the directed part; n_bytes, b0 and b1 are typed in where obvious
  typedef struct {
    row_kind_t   kind;
    req_t        req;
    logic        idx;
    logic [15:0] val;
    int          n_bytes;
    logic [7:0]  b0;
    logic [7:0]  b1;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [15:0] in_reg_addr;
  logic [6:0]  in_reg_count;
  logic [15:0] in_data_word;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_frame_end;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  // framer state as the testbench sees it
  logic [7:0]  st_station;
  logic [15:0] st_base;
  logic        st_open;
  logic [15:0] st_crc;
  logic [6:0]  st_words_left;

  frame_byte_t due_bytes[$];   // frame bytes still to come, oldest first
  frame_byte_t want;
  plan_row_t   plan[$];

  // bytes predicted for the latest beat, for the typed-in rows
  int         pred_n;
  logic [7:0] pred_b0;
  logic [7:0] pred_b1;

  bit calm = 1'b0;             // no gaps and no stalls in this stretch
  int stall_left = 0;
  int n_err = 0;
  int n_items = 0;
  int n_multi = 0;
  int n_cfg = 0;
  int n_checked = 0;
  int n_frames = 0;

  modbus_rtu_request_framer #(
    .MAX_WRITE_WORDS(MAX_WRITE_WORDS)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_reg_addr  (in_reg_addr),
    .in_reg_count (in_reg_count),
    .in_data_word (in_data_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tx_byte  (out_tx_byte),
    .out_frame_end(out_frame_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // crc-16/modbus, reflected, one byte at a time
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = (r >> 1) ^ (r[0] ? mrf_pkg::CRC_POLY : 16'h0000);
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last);
    frame_byte_t fb;
    fb.tx   = b;
    fb.last = last;
    due_bytes.push_back(fb);
    if (pred_n == 0) pred_b0 = b;
    if (pred_n == 1) pred_b1 = b;
    pred_n++;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    push_byte(b, 1'b0);
    st_crc = crc16_step(st_crc, b);
  endfunction

  // words go out high byte first
  function automatic void put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endfunction

  // crc goes out low byte first and closes the frame
  function automatic void put_crc_tail();
    push_byte(st_crc[7:0], 1'b0);
    push_byte(st_crc[15:8], 1'b1);
    st_crc        = mrf_pkg::CRC_INIT;
    st_open       = 1'b0;
    st_words_left = '0;
  endfunction

  function automatic void build_frame_bytes(input req_t r);
    logic [15:0] full;
    logic [6:0]  n;
    pred_n = 0;
    if (st_open) begin
      // continuation beat: only the data word counts
      put_word(r.data);
      if (st_words_left != 0) st_words_left--;
      if (st_words_left == 0) put_crc_tail();
    end else begin
      full   = r.addr + st_base;
      st_crc = mrf_pkg::CRC_INIT;
      if (r.op == OP_READ) begin
        // count goes out as given, even zero or above the limit
        put_byte(st_station);
        put_byte(mrf_pkg::FN_READ);
        put_word(full);
        put_word({9'd0, r.cnt});
        put_crc_tail();
      end else if (r.cnt != 0) begin
        n = (r.cnt > MAX_WRITE_WORDS) ? 7'(MAX_WRITE_WORDS) : r.cnt;
        put_byte(st_station);
        if (n == 1) begin
          put_byte(mrf_pkg::FN_WRITE_ONE);
          put_word(full);
          put_word(r.data);
          put_crc_tail();
        end else begin
          put_byte(mrf_pkg::FN_WRITE_MANY);
          put_word(full);
          put_word({9'd0, n});
          put_byte({n, 1'b0});
          put_word(r.data);
          st_open       = 1'b1;
          st_words_left = n - 7'd1;
          n_multi++;
        end
      end
      // a write with count zero leaves no trace
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic req_t random_fields();
    req_t r;
    r.op   = req_op_t'($urandom_range(0, 1));
    r.addr = 16'($urandom);
    r.cnt  = 7'($urandom);
    r.data = 16'($urandom);
    return r;
  endfunction

  function automatic logic [15:0] pick_setting(input logic [15:0] top);
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return top;
      default: return 16'($urandom) & top;
    endcase
  endfunction

  function automatic plan_row_t req_row(input req_op_t op, input logic [15:0] addr,
                                        input logic [6:0] cnt, input logic [15:0] data,
                                        input int n, input logic [7:0] b0, input logic [7:0] b1);
    plan_row_t p;
    p.kind     = ROW_REQ;
    p.req.op   = op;
    p.req.addr = addr;
    p.req.cnt  = cnt;
    p.req.data = data;
    p.idx      = mrf_pkg::CFG_STATION;
    p.val      = 16'h0000;
    p.n_bytes  = n;
    p.b0       = b0;
    p.b1       = b1;
    return p;
  endfunction

  function automatic plan_row_t ctl_row(input row_kind_t k, input logic idx,
                                        input logic [15:0] val);
    plan_row_t p;
    p      = req_row(OP_READ, 16'h0000, 7'd0, 16'h0000, NO_TYPED, 8'h00, 8'h00);
    p.kind = k;
    p.idx  = idx;
    p.val  = val;
    return p;
  endfunction

  // one request beat: entered and left just after a falling edge;
  // valid stays up between back-to-back beats
  task automatic send_request(input req_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= r.op;
    in_reg_addr  <= r.addr;
    in_reg_count <= r.cnt;
    in_data_word <= r.data;
    do @(posedge clk); while (in_stall);
    build_frame_bytes(r);
    n_items++;
    @(negedge clk);
  endtask

  // drop valid, let every due byte come out, then give an ignored beat time to clear
  task automatic settle();
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == mrf_pkg::CFG_STATION) st_station = val[7:0];
    else st_base = val;
    n_cfg++;
  endtask

  // mostly well-formed frames; count-zero writes are the noise
  task automatic random_frame();
    req_t r;
    int   sel;
    r     = random_fields();
    r.op  = OP_WRITE;
    sel   = $urandom_range(0, 99);
    if (sel < 30) begin
      r.op  = OP_READ;
      r.cnt = 7'($urandom_range(0, 127));
    end else if (sel < 50) begin
      r.cnt = 7'd1;
    end else if (sel < 56) begin
      r.cnt = 7'd0;
    end else if (sel < 92) begin
      r.cnt = 7'($urandom_range(2, 6));
    end else begin
      r.cnt = 7'($urandom_range(7, 40));
    end
    send_request(r);
    while (st_open) begin
      // now and then retune a register while the frame waits for words
      if ($urandom_range(0, 15) == 0) begin
        settle();
        set_register($urandom_range(0, 1) ? mrf_pkg::CFG_BASE : mrf_pkg::CFG_STATION,
                     pick_setting(16'hFFFF));
      end
      send_request(random_fields());
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_bytes.size() == 0) begin
        $error("tx_byte: no byte due, got %h (frame_end %b)", out_tx_byte, out_frame_end);
        n_err++;
      end else begin
        want = due_bytes.pop_front();
        if (out_tx_byte !== want.tx) begin
          $error("tx_byte: expected %h, got %h", want.tx, out_tx_byte);
          n_err++;
        end
        if (out_frame_end !== want.last) begin
          $error("frame_end: expected %b, got %b", want.last, out_frame_end);
          n_err++;
        end
      end
      n_checked++;
      if (out_frame_end) n_frames++;
      stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  // frame side hold-off, drawn per byte
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- main flow

  initial begin
    int target;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_READ;
    in_reg_addr   = 16'h0000;
    in_reg_count  = 7'd0;
    in_data_word  = 16'h0000;
    cfg_wr_en     = 1'b0;
    cfg_index     = mrf_pkg::CFG_STATION;
    cfg_wdata     = 16'h0000;
    st_station    = 8'h03;
    st_base       = 16'h0000;
    st_open       = 1'b0;
    st_crc        = mrf_pkg::CRC_INIT;
    st_words_left = '0;

    // reset values: station 3, base 0
    plan.push_back(req_row(OP_READ,  16'h0000, 7'd1,   16'h0000, 8, 8'h03,
                           mrf_pkg::FN_READ));
    // top address, count above the standard limit goes out as is
    plan.push_back(req_row(OP_READ,  16'hFFFF, 7'd127, 16'hFFFF, 8, 8'h03,
                           mrf_pkg::FN_READ));
    plan.push_back(req_row(OP_READ,  16'h1234, 7'd0,   16'h0000, 8, 8'h03,
                           mrf_pkg::FN_READ));
    plan.push_back(req_row(OP_WRITE, 16'h0000, 7'd1,   16'hFFFF, 8, 8'h03,
                           mrf_pkg::FN_WRITE_ONE));
    // write of zero registers is dropped
    plan.push_back(req_row(OP_WRITE, 16'hFFFF, 7'd0,   16'hAAAA, 0, 8'h00, 8'h00));
    plan.push_back(req_row(OP_WRITE, 16'h0010, 7'd2,   16'h0000, 9, 8'h03,
                           mrf_pkg::FN_WRITE_MANY));
    // closing word: op and count of this beat do not matter
    plan.push_back(req_row(OP_READ,  16'hFFFF, 7'd0,   16'hFFFF, 4, 8'hFF, 8'hFF));
    // base at its top, address sum wraps
    plan.push_back(ctl_row(ROW_CFG, mrf_pkg::CFG_BASE, 16'hFFFF));
    plan.push_back(req_row(OP_READ,  16'h0001, 7'd3,   16'h0000, 8, 8'h03,
                           mrf_pkg::FN_READ));
    plan.push_back(ctl_row(ROW_CFG, mrf_pkg::CFG_STATION, 16'h00FF));
    // count above the write limit saturates, in the frame and in words taken
    plan.push_back(req_row(OP_WRITE, 16'h8000, 7'd127, 16'h5555, 9, 8'hFF,
                           mrf_pkg::FN_WRITE_MANY));
    plan.push_back(ctl_row(ROW_FILL, mrf_pkg::CFG_STATION, 16'h0000));
    plan.push_back(req_row(OP_WRITE, 16'h7FFF, 7'd123, 16'hFFFF, 9, 8'hFF,
                           mrf_pkg::FN_WRITE_MANY));
    plan.push_back(ctl_row(ROW_FILL, mrf_pkg::CFG_STATION, 16'h0000));
    // registers change while a write waits for words; the open frame keeps its bytes
    plan.push_back(req_row(OP_WRITE, 16'h0100, 7'd3,   16'h0001, 9, 8'hFF,
                           mrf_pkg::FN_WRITE_MANY));
    plan.push_back(ctl_row(ROW_CFG, mrf_pkg::CFG_STATION, 16'h0000));
    plan.push_back(ctl_row(ROW_CFG, mrf_pkg::CFG_BASE, 16'h0000));
    plan.push_back(req_row(OP_WRITE, 16'hFFFF, 7'd127, 16'h0203, 2, 8'h02, 8'h03));
    plan.push_back(req_row(OP_WRITE, 16'h0000, 7'd0,   16'h0405, 4, 8'h04, 8'h05));
    plan.push_back(req_row(OP_READ,  16'h0000, 7'd124, 16'h0000, 8, 8'h00,
                           mrf_pkg::FN_READ));
    plan.push_back(req_row(OP_WRITE, 16'hFFFF, 7'd1,   16'h0000, 8, 8'h00,
                           mrf_pkg::FN_WRITE_ONE));
    plan.push_back(req_row(OP_WRITE, 16'h5A5A, 7'd64,  16'hA5A5, NO_TYPED, 8'h00, 8'h00));
    plan.push_back(ctl_row(ROW_FILL, mrf_pkg::CFG_STATION, 16'h0000));

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          set_register(plan[i].idx, plan[i].val);
        end
        ROW_FILL: begin
          while (st_open) send_request(random_fields());
        end
        default: begin
          send_request(plan[i].req);
          if (plan[i].n_bytes != NO_TYPED) begin
            if (pred_n != plan[i].n_bytes) begin
              $error("byte count of row %0d: expected %0d, got %0d", i, plan[i].n_bytes, pred_n);
              n_err++;
            end else if (pred_n >= 2 && (pred_b0 != plan[i].b0 || pred_b1 != plan[i].b1)) begin
              $error("leading bytes of row %0d: expected %h %h, got %h %h",
                     i, plan[i].b0, plan[i].b1, pred_b0, pred_b1);
              n_err++;
            end
          end
        end
      endcase
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      set_register(mrf_pkg::CFG_STATION, pick_setting(16'h00FF));
      set_register(mrf_pkg::CFG_BASE, pick_setting(16'hFFFF));
      calm   = ($urandom_range(0, 3) == 0);
      target = n_items + PHASE_ITEMS;
      while (n_items < target) random_frame();
    end
    calm = 1'b0;

    settle();
    $display("sent %0d request beats, %0d multi-register frames, %0d register writes",
             n_items, n_multi, n_cfg);
    $display("compared %0d frame bytes across %0d closed frames, %0d mismatches",
             n_checked, n_frames, n_err);
    if (n_err == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // hard stop if the handshakes hang
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ modbus_rtu_request_framer.f @@
rtl/core/mrf_pkg.sv
rtl/core/mrf_frame_builder.sv
rtl/core/mrf_byte_serializer.sv
rtl/core/modbus_rtu_request_framer.sv
rtl/core/mrf_checker.sv
verif/tb_top.sv
